// ===== rtl/ratab_pkg.sv =====
// ----------------------------------------------------------------------------
// ratab_pkg
// Shared types, constants and control structs for the identifier activity
// table.
// ----------------------------------------------------------------------------
package ratab_pkg;

    localparam int ID_BITS_DEF     = 16;
    localparam int TIME_BITS_DEF   = 32;
    localparam int SAMPLE_BITS_DEF = 48;
    localparam logic [31:0] TTL_RESET = 32'd1000000;

    typedef enum logic [1:0] {
        KIND_OBSERVE = 2'd0,
        KIND_EXPIRE  = 2'd1,
        KIND_QUERY   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_TAIL,
        ST_LOOKUP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] rnti_value;
        logic [31:0] event_time;
        logic [47:0] event_sample;
        logic [31:0] cutoff_time;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic        is_new;
        logic [15:0] rnti_out;
        logic [31:0] first_time;
        logic [31:0] last_time;
        logic [47:0] first_sample_out;
        logic [47:0] last_sample_out;
        logic [31:0] seen_total;
        logic [15:0] revival_total;
        logic [16:0] active_entries;
    } out_item_t;

    typedef struct packed {
        logic take;
        logic clr_wr;
        logic sweep_rd;
        logic lookup;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/ratab_ram.sv =====
// ----------------------------------------------------------------------------
// ratab_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ratab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/ratab_ctrl.sv =====
// ----------------------------------------------------------------------------
// ratab_ctrl
// Sequencer for clearing pass, lookups, updates and expire sweeps.
// ----------------------------------------------------------------------------
module ratab_ctrl
    import ratab_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_kind,
    output logic       in_ready,
    input  status_t    status,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_kind == KIND_EXPIRE) ? ST_SWEEP : ST_LOOKUP;
                end
            end
            ST_SWEEP:
            begin
                if (status.cnt_last)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:   state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:  cmd.clr_wr = 1'b1;
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_SWEEP:  cmd.sweep_rd = 1'b1;
            ST_TAIL:   cmd = '0;
            ST_LOOKUP: cmd.lookup = 1'b1;
            ST_FINISH: cmd.commit = status.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

// ===== rtl/ratab_dp.sv =====
// ----------------------------------------------------------------------------
// ratab_dp
// Datapath: valid and record memories, item and result registers, record
// update, expire compare and the active entry count.
// ----------------------------------------------------------------------------
module ratab_dp
    import ratab_pkg::*;
#(
    parameter int ID_BITS     = ID_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  logic      cfg_we,
    input  logic [31:0] cfg_wdata,
    input  cmd_t      cmd,
    output status_t   status,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int DEPTH = 1 << ID_BITS;
    localparam int REC_W = 2 * TIME_BITS + 2 * SAMPLE_BITS + 48;
    localparam int GAP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [31:0]            ttl_reg;
    logic [1:0]             kind_reg;
    logic [ID_BITS-1:0]     idx_reg;
    logic [TIME_BITS-1:0]   time_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic [TIME_BITS-1:0]   cut_reg;
    logic [ID_BITS-1:0]     cnt_reg;
    logic                   chk_reg;
    logic [ID_BITS-1:0]     chk_addr_reg;
    logic [ID_BITS:0]       act_reg;
    logic [ID_BITS:0]       act_next;
    logic                   out_valid_reg;
    out_item_t              out_reg;

    logic                   vld_rd;
    logic [REC_W-1:0]       rec_rd;
    logic [ID_BITS-1:0]     rd_addr;
    logic                   rd_en;
    logic                   vld_we;
    logic [ID_BITS-1:0]     vld_waddr;
    logic                   vld_wdata;
    logic                   rec_we;
    logic [REC_W-1:0]       rec_wdata;

    logic [TIME_BITS-1:0]   rd_ft, rd_lt;
    logic [SAMPLE_BITS-1:0] rd_fs, rd_ls;
    logic [31:0]            rd_seen;
    logic [15:0]            rd_rev;

    logic [TIME_BITS-1:0]   nw_ft, nw_lt;
    logic [SAMPLE_BITS-1:0] nw_fs, nw_ls;
    logic [31:0]            nw_seen;
    logic [15:0]            nw_rev;

    logic                   is_obs;
    logic                   create;
    logic                   revive;
    logic [GAP_W-1:0]       gap;
    logic                   exp_hit;
    logic                   found;
    out_item_t              res;

    assign {rd_ft, rd_lt, rd_fs, rd_ls, rd_seen, rd_rev} = rec_rd;

    assign rd_en   = cmd.lookup | cmd.sweep_rd;
    assign rd_addr = cmd.lookup ? idx_reg : cnt_reg;

    assign is_obs  = (kind_reg == KIND_OBSERVE);
    assign create  = is_obs && !vld_rd;
    assign exp_hit = chk_reg && vld_rd && (rd_lt < cut_reg);

    // revival only for a forward gap beyond the ttl
    assign gap    = GAP_W'(time_reg - rd_lt);
    assign revive = (time_reg > rd_lt) && (gap > GAP_W'(ttl_reg));

    always_comb
    begin
        if (create)
        begin
            nw_ft   = time_reg;
            nw_lt   = time_reg;
            nw_fs   = smp_reg;
            nw_ls   = smp_reg;
            nw_seen = 32'd1;
            nw_rev  = 16'd0;
        end
        else
        begin
            nw_ft   = rd_ft;
            nw_lt   = is_obs ? time_reg : rd_lt;
            nw_fs   = rd_fs;
            nw_ls   = is_obs ? smp_reg : rd_ls;
            nw_seen = (is_obs && rd_seen != '1) ? rd_seen + 32'd1 : rd_seen;
            nw_rev  = (is_obs && revive && rd_rev != '1) ? rd_rev + 16'd1 : rd_rev;
        end
    end

    assign rec_wdata = {nw_ft, nw_lt, nw_fs, nw_ls, nw_seen, nw_rev};
    assign rec_we    = cmd.commit && is_obs;

    always_comb
    begin
        vld_we    = 1'b0;
        vld_waddr = idx_reg;
        vld_wdata = 1'b1;
        priority if (cmd.clr_wr)
        begin
            vld_we    = 1'b1;
            vld_waddr = cnt_reg;
            vld_wdata = 1'b0;
        end
        else if (exp_hit)
        begin
            vld_we    = 1'b1;
            vld_waddr = chk_addr_reg;
            vld_wdata = 1'b0;
        end
        else if (rec_we)
        begin
            vld_we = 1'b1;
        end
    end

    always_comb
    begin
        act_next = act_reg;
        priority if (exp_hit)
        begin
            if (act_reg != '0)
            begin
                act_next = act_reg - 1'b1;
            end
        end
        else if (cmd.commit && create)
        begin
            if (act_reg < (ID_BITS+1)'(DEPTH))
            begin
                act_next = act_reg + 1'b1;
            end
        end
    end

    assign found = is_obs || vld_rd;

    always_comb
    begin
        res                  = '0;
        res.found            = found;
        res.is_new           = create;
        res.active_entries   = 17'(act_next);
        if (found)
        begin
            res.rnti_out         = 16'(idx_reg);
            res.first_time       = 32'(nw_ft);
            res.last_time        = 32'(nw_lt);
            res.first_sample_out = 48'(nw_fs);
            res.last_sample_out  = 48'(nw_ls);
            res.seen_total       = nw_seen;
            res.revival_total    = nw_rev;
        end
    end

    ratab_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_vld_ram (
        .clk     (clk),
        .wr_en   (vld_we),
        .wr_addr (vld_waddr),
        .wr_data (vld_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (vld_rd)
    );

    ratab_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (rec_we),
        .wr_addr (idx_reg),
        .wr_data (rec_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rec_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg       <= TTL_RESET;
            cnt_reg       <= '0;
            chk_reg       <= 1'b0;
            act_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ttl_reg <= cfg_wdata;
            end
            if (cmd.clr_wr || cmd.sweep_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            chk_reg <= cmd.sweep_rd;
            act_reg <= act_next;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg <= cnt_reg;
        if (cmd.take)
        begin
            kind_reg <= in_data.kind;
            idx_reg  <= in_data.rnti_value[ID_BITS-1:0];
            time_reg <= TIME_BITS'(in_data.event_time);
            smp_reg  <= SAMPLE_BITS'(in_data.event_sample);
            cut_reg  <= TIME_BITS'(in_data.cutoff_time);
        end
        if (cmd.commit)
        begin
            out_reg <= res;
        end
    end

    assign status.cnt_last = &cnt_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;

endmodule

// ===== rtl/rnti_activity_table_top.sv =====
// ----------------------------------------------------------------------------
// rnti_activity_table_top
// Directly indexed per-identifier activity table with expire sweep.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the valid map, one entry
// per cycle over all 2^ID_BITS entries (65536 by default), and takes no item
// until it ends; ttl writes are taken at any time. Observe and query items go
// through accept, memory read, then update and result, which waits while the
// output register is full. An expire item walks the whole table through the
// record memory read port, one entry per cycle, before its lookup and result.
// A result waits in an output register; the next item is accepted meanwhile.
module rnti_activity_table_top
    import ratab_pkg::*;
#(
    parameter int ID_BITS     = ID_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    ratab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (in_data.kind),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ratab_dp #(
        .ID_BITS     (ID_BITS),
        .TIME_BITS   (TIME_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
